// File: design/i2cm_pkg.sv
// Shared types, constants and helpers for the I2C master bit engine.
// No dependencies; used by i2cm_phase_fsm and i2c_master_bit_engine_core.
package i2cm_pkg;

  // Width of the per-phase delay timer
  localparam int TIMER_W = 8;

  // Operation codes carried on the command channel
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WACK  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // Bus phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_SP_C    = 4'd5,
    PH_WR_LO   = 4'd6,
    PH_WR_HI   = 4'd7,
    PH_WR_TAIL = 4'd8,
    PH_RD_LO   = 4'd9,
    PH_RD_HI   = 4'd10,
    PH_AK_LO   = 4'd11,
    PH_AK_HI   = 4'd12,
    PH_WA_REL  = 4'd13,
    PH_WA_CLK  = 4'd14,
    PH_WA_POLL = 4'd15
  } phase_t;

  // Configuration seen by the phase machine
  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] ack_timeout_polls;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } result_t;

  // Timer reload: zero counts as one, large values saturate to the timer range
  function automatic logic [TIMER_W-1:0] timer_load(input logic [7:0] hp);
    logic [15:0] ext;
    logic [15:0] lim;
    ext = {8'd0, hp};
    lim = 16'((32'd1 << TIMER_W) - 32'd1);
    if (ext == 16'd0) begin
      ext = 16'd1;
    end
    if (ext > lim) begin
      ext = lim;
    end
    return ext[TIMER_W-1:0];
  endfunction

endpackage

// File: design/i2cm_phase_fsm.sv
// Phase machine of the I2C master: bus state registers and one-step next-state logic.
// Depends on i2cm_pkg.
module i2cm_phase_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [2:0]           operation,
  input  logic [7:0]           data_byte,
  input  logic                 send_ack,
  input  logic                 sda_in,
  input  i2cm_pkg::cfg_t       cfg,
  output i2cm_pkg::result_t    res_next
);

  i2cm_pkg::phase_t               phase, phase_next;
  logic [2:0]                     bit_index, bit_index_next;
  logic [7:0]                     shift_byte, shift_byte_next;
  logic [i2cm_pkg::TIMER_W-1:0]   delay_timer, delay_timer_next;
  logic [7:0]                     poll_count, poll_count_next;
  logic                           ack_choice, ack_choice_next;
  logic                           scl_line, scl_line_next;
  logic                           sda_line, sda_line_next;
  logic                           failure_flag, failure_flag_next;
  logic [7:0]                     read_reg, read_reg_next;
  logic                           done;
  logic [i2cm_pkg::TIMER_W-1:0]   reload;
  logic [7:0]                     poll_inc;
  logic [7:0]                     poll_limit;
  logic [7:0]                     shift_up;

  assign reload     = i2cm_pkg::timer_load(cfg.half_period_ticks);
  assign poll_inc   = poll_count + 8'd1;
  assign poll_limit = (cfg.ack_timeout_polls == 8'd0) ? 8'd1 : cfg.ack_timeout_polls;
  assign shift_up   = {shift_byte[6:0], 1'b0};

  // State registers, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cm_pkg::PH_IDLE;
      bit_index    <= '0;
      shift_byte   <= '0;
      delay_timer  <= '0;
      poll_count   <= '0;
      ack_choice   <= 1'b0;
      scl_line     <= 1'b1;
      sda_line     <= 1'b1;
      failure_flag <= 1'b0;
      read_reg     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      delay_timer  <= delay_timer_next;
      poll_count   <= poll_count_next;
      ack_choice   <= ack_choice_next;
      scl_line     <= scl_line_next;
      sda_line     <= sda_line_next;
      failure_flag <= failure_flag_next;
      read_reg     <= read_reg_next;
    end
  end

  // Next state for one beat
  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    delay_timer_next  = delay_timer;
    poll_count_next   = poll_count;
    ack_choice_next   = ack_choice;
    scl_line_next     = scl_line;
    sda_line_next     = sda_line;
    failure_flag_next = failure_flag;
    read_reg_next     = read_reg;
    done              = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      // Command decode; ticks and unused codes leave everything alone
      case (operation)
        i2cm_pkg::OP_START: begin
          scl_line_next     = 1'b1;
          sda_line_next     = 1'b1;
          phase_next        = i2cm_pkg::PH_ST_A;
          delay_timer_next  = reload;
          failure_flag_next = 1'b0;
        end
        i2cm_pkg::OP_STOP: begin
          scl_line_next     = 1'b0;
          sda_line_next     = 1'b0;
          phase_next        = i2cm_pkg::PH_SP_A;
          delay_timer_next  = reload;
          failure_flag_next = 1'b0;
        end
        i2cm_pkg::OP_WRITE: begin
          shift_byte_next   = data_byte;
          bit_index_next    = '0;
          scl_line_next     = 1'b0;
          sda_line_next     = data_byte[7];
          phase_next        = i2cm_pkg::PH_WR_LO;
          delay_timer_next  = reload;
          failure_flag_next = 1'b0;
        end
        i2cm_pkg::OP_READ: begin
          shift_byte_next   = '0;
          bit_index_next    = '0;
          ack_choice_next   = send_ack;
          scl_line_next     = 1'b0;
          sda_line_next     = 1'b1;
          phase_next        = i2cm_pkg::PH_RD_LO;
          delay_timer_next  = reload;
          failure_flag_next = 1'b0;
        end
        i2cm_pkg::OP_WACK: begin
          sda_line_next     = 1'b1;
          phase_next        = i2cm_pkg::PH_WA_REL;
          delay_timer_next  = reload;
          failure_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (operation == i2cm_pkg::OP_TICK) begin
      if (phase == i2cm_pkg::PH_WA_POLL) begin
        // Ack poll: low SDA ends the command, timeout falls into a stop
        if (!sda_in) begin
          scl_line_next = 1'b0;
          phase_next    = i2cm_pkg::PH_IDLE;
          done          = 1'b1;
        end else begin
          poll_count_next = poll_inc;
          if (poll_inc >= poll_limit) begin
            failure_flag_next = 1'b1;
            scl_line_next     = 1'b0;
            sda_line_next     = 1'b0;
            phase_next        = i2cm_pkg::PH_SP_A;
            delay_timer_next  = reload;
          end
        end
      end else if (delay_timer > i2cm_pkg::TIMER_W'(1)) begin
        delay_timer_next = delay_timer - i2cm_pkg::TIMER_W'(1);
      end else begin
        // Phase expired
        case (phase)
          i2cm_pkg::PH_ST_A: begin
            sda_line_next    = 1'b0;
            phase_next       = i2cm_pkg::PH_ST_B;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_ST_B: begin
            scl_line_next = 1'b0;
            phase_next    = i2cm_pkg::PH_IDLE;
            done          = 1'b1;
          end
          i2cm_pkg::PH_SP_A: begin
            scl_line_next    = 1'b1;
            phase_next       = i2cm_pkg::PH_SP_B;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_SP_B: begin
            sda_line_next    = 1'b1;
            phase_next       = i2cm_pkg::PH_SP_C;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_SP_C: begin
            phase_next = i2cm_pkg::PH_IDLE;
            done       = 1'b1;
          end
          i2cm_pkg::PH_WR_LO: begin
            scl_line_next    = 1'b1;
            phase_next       = i2cm_pkg::PH_WR_HI;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_WR_HI: begin
            scl_line_next    = 1'b0;
            phase_next       = i2cm_pkg::PH_WR_TAIL;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_WR_TAIL: begin
            if (bit_index == 3'd7) begin
              phase_next = i2cm_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              bit_index_next   = bit_index + 3'd1;
              shift_byte_next  = shift_up;
              sda_line_next    = shift_up[7];
              phase_next       = i2cm_pkg::PH_WR_LO;
              delay_timer_next = reload;
            end
          end
          i2cm_pkg::PH_RD_LO: begin
            // sample SDA as SCL rises
            scl_line_next    = 1'b1;
            shift_byte_next  = {shift_byte[6:0], sda_in};
            phase_next       = i2cm_pkg::PH_RD_HI;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_RD_HI: begin
            scl_line_next    = 1'b0;
            delay_timer_next = reload;
            if (bit_index == 3'd7) begin
              read_reg_next = shift_byte;
              sda_line_next = !ack_choice;
              phase_next    = i2cm_pkg::PH_AK_LO;
            end else begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = i2cm_pkg::PH_RD_LO;
            end
          end
          i2cm_pkg::PH_AK_LO: begin
            scl_line_next    = 1'b1;
            phase_next       = i2cm_pkg::PH_AK_HI;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_AK_HI: begin
            scl_line_next = 1'b0;
            phase_next    = i2cm_pkg::PH_IDLE;
            done          = 1'b1;
          end
          i2cm_pkg::PH_WA_REL: begin
            scl_line_next    = 1'b1;
            phase_next       = i2cm_pkg::PH_WA_CLK;
            delay_timer_next = reload;
          end
          i2cm_pkg::PH_WA_CLK: begin
            poll_count_next = '0;
            phase_next      = i2cm_pkg::PH_WA_POLL;
          end
          default: begin
            phase_next = i2cm_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result of this beat, taken from the next state
  always_comb begin
    res_next.scl_level  = scl_line_next;
    res_next.sda_level  = sda_line_next;
    res_next.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
    res_next.done_res   = done;
    res_next.read_data  = read_reg_next;
    res_next.ack_failed = failure_flag_next;
  end

endmodule

// File: design/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: config registers, handshakes, result register.
// Depends on i2cm_pkg and i2cm_phase_fsm.
//
//   channel   signals                               direction
//   -------   -----------------------------------   ---------
//   in        in_valid/in_ready + command fields    input
//   out       out_valid/out_ready + result fields   output
//   cfg       cfg_we, cfg_index, cfg_wdata          input
//
// Each accepted beat updates the phase machine and yields one result beat in the
// result register on the next cycle; a beat can be taken every clock unless stalled.
// The single result register decides throughput: in_ready is high whenever it is
// empty or being drained in the same cycle.
// Synchronous reset puts the bus lines high, the engine idle, and the config
// registers at 5 half-period ticks and 250 ack polls.
module i2c_master_bit_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] operation,
  input  logic [7:0] data_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       ack_failed,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::result_t res_next;
  i2cm_pkg::result_t res;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RST;
      cfg.ack_timeout_polls <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_wdata;
        i2cm_pkg::CFG_ACK_TIMEOUT: cfg.ack_timeout_polls <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  i2cm_phase_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .operation (operation),
    .data_byte (data_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign scl_level  = res.scl_level;
  assign sda_level  = res.sda_level;
  assign busy_res   = res.busy_res;
  assign done_res   = res.done_res;
  assign read_data  = res.read_data;
  assign ack_failed = res.ack_failed;

endmodule

// File: dv/tb_i2c_master_bit_engine_core.sv
// Self-checking testbench for the I2C master bit engine core.
// Needs i2cm_pkg and the design sources; a table of directed beats, then random
// command sequences, checked against an in-bench phase-machine model or table rows.
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_core;
  import i2cm_pkg::*;

  // Operation codes outside the command set, ignored by the block
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // Run limit: far above the slowest legal run
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] operation = OP_TICK;
  logic [7:0] data_byte = 8'h00;
  logic       send_ack = 1'b0;
  logic       sda_in = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_failed;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_HALF_PERIOD;
  logic [7:0] cfg_wdata = 8'h00;

  i2c_master_bit_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .data_byte (data_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_data (read_data),
    .ack_failed(ack_failed),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Run limit
  initial begin
    #RUN_LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------
  // Bus engine model: own copy of config and state
  // ---------------------------------------------------------------
  logic [7:0] half_ticks;
  logic [7:0] poll_limit;
  phase_t     bus_ph;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [7:0] hold_cnt;
  logic [7:0] poll_cnt;
  logic       ack_sel;
  logic       scl_m;
  logic       sda_m;
  logic       fail_m;
  logic [7:0] rd_byte;
  bit         beat_counted;  // last beat started a command or advanced time

  result_t    result_q[$];
  int         err_cnt = 0;
  int         hold_req = 0;   // long receiver hold-off, picked up by the receiver
  int         tx_burst = 0;
  int         rx_burst = 0;

  function automatic result_t mk_res(logic scl, logic sda, logic busy, logic done,
                                     logic [7:0] rd, logic fail);
    result_t r;
    r.scl_level  = scl;
    r.sda_level  = sda;
    r.busy_res   = busy;
    r.done_res   = done;
    r.read_data  = rd;
    r.ack_failed = fail;
    return r;
  endfunction

  function automatic void engine_reset();
    half_ticks = HALF_PERIOD_RST;
    poll_limit = ACK_TIMEOUT_RST;
    bus_ph     = PH_IDLE;
    bit_cnt    = '0;
    shreg      = '0;
    hold_cnt   = '0;
    poll_cnt   = '0;
    ack_sel    = 1'b0;
    scl_m      = 1'b1;
    sda_m      = 1'b1;
    fail_m     = 1'b0;
    rd_byte    = '0;
  endfunction

  // Enter a timed phase; a zero setting counts as one tick
  function automatic void enter_phase(phase_t nxt);
    bus_ph   = nxt;
    hold_cnt = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
  endfunction

  // One tick while busy; returns 1 when the command completes
  function automatic bit engine_tick(logic sdai);
    logic [7:0] lim;
    if (bus_ph == PH_WA_POLL) begin
      if (!sdai) begin
        scl_m  = 1'b0;
        bus_ph = PH_IDLE;
        return 1'b1;
      end
      poll_cnt = poll_cnt + 8'd1;
      lim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
      if (poll_cnt >= lim) begin
        // ack timeout: flag it and run a stop
        fail_m = 1'b1;
        scl_m  = 1'b0;
        sda_m  = 1'b0;
        enter_phase(PH_SP_A);
      end
      return 1'b0;
    end
    if (hold_cnt > 8'd1) begin
      hold_cnt = hold_cnt - 8'd1;
      return 1'b0;
    end
    case (bus_ph)
      PH_ST_A: begin
        sda_m = 1'b0;
        enter_phase(PH_ST_B);
      end
      PH_ST_B: begin
        scl_m  = 1'b0;
        bus_ph = PH_IDLE;
        return 1'b1;
      end
      PH_SP_A: begin
        scl_m = 1'b1;
        enter_phase(PH_SP_B);
      end
      PH_SP_B: begin
        sda_m = 1'b1;
        enter_phase(PH_SP_C);
      end
      PH_SP_C: begin
        bus_ph = PH_IDLE;
        return 1'b1;
      end
      PH_WR_LO: begin
        scl_m = 1'b1;
        enter_phase(PH_WR_HI);
      end
      PH_WR_HI: begin
        scl_m = 1'b0;
        enter_phase(PH_WR_TAIL);
      end
      PH_WR_TAIL: begin
        if (bit_cnt >= 4'd7) begin
          bus_ph = PH_IDLE;
          return 1'b1;
        end
        bit_cnt = bit_cnt + 4'd1;
        shreg   = {shreg[6:0], 1'b0};
        sda_m   = shreg[7];
        enter_phase(PH_WR_LO);
      end
      PH_RD_LO: begin
        // sample on the rising SCL
        scl_m = 1'b1;
        shreg = {shreg[6:0], sdai};
        enter_phase(PH_RD_HI);
      end
      PH_RD_HI: begin
        scl_m = 1'b0;
        if (bit_cnt >= 4'd7) begin
          rd_byte = shreg;
          sda_m   = ~ack_sel;
          enter_phase(PH_AK_LO);
        end else begin
          bit_cnt = bit_cnt + 4'd1;
          enter_phase(PH_RD_LO);
        end
      end
      PH_AK_LO: begin
        scl_m = 1'b1;
        enter_phase(PH_AK_HI);
      end
      PH_AK_HI: begin
        scl_m  = 1'b0;
        bus_ph = PH_IDLE;
        return 1'b1;
      end
      PH_WA_REL: begin
        scl_m = 1'b1;
        enter_phase(PH_WA_CLK);
      end
      PH_WA_CLK: begin
        poll_cnt = '0;
        bus_ph   = PH_WA_POLL;
      end
      default: bus_ph = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Expected result of one accepted beat
  function automatic result_t predict_beat(logic [2:0] op, logic [7:0] data, logic ack,
                                           logic sdai);
    bit done;
    done = 1'b0;
    beat_counted = 1'b0;
    if (bus_ph == PH_IDLE) begin
      beat_counted = 1'b1;
      case (op)
        OP_START: begin
          scl_m = 1'b1;
          sda_m = 1'b1;
          enter_phase(PH_ST_A);
        end
        OP_STOP: begin
          scl_m = 1'b0;
          sda_m = 1'b0;
          enter_phase(PH_SP_A);
        end
        OP_WRITE: begin
          shreg   = data;
          bit_cnt = '0;
          scl_m   = 1'b0;
          sda_m   = data[7];
          enter_phase(PH_WR_LO);
        end
        OP_READ: begin
          shreg   = '0;
          bit_cnt = '0;
          ack_sel = ack;
          scl_m   = 1'b0;
          sda_m   = 1'b1;
          enter_phase(PH_RD_LO);
        end
        OP_WACK: begin
          sda_m = 1'b1;
          enter_phase(PH_WA_REL);
        end
        default: beat_counted = 1'b0;
      endcase
      if (beat_counted) fail_m = 1'b0;
    end else if (op == OP_TICK) begin
      beat_counted = 1'b1;
      done = engine_tick(sdai);
    end
    return mk_res(scl_m, sda_m, bus_ph != PH_IDLE, done, rd_byte, fail_m);
  endfunction

  // ---------------------------------------------------------------
  // Mismatch reporting and result check
  // ---------------------------------------------------------------
  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (result_q.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    want = result_q.pop_front();
    if (got.scl_level !== want.scl_level)
      report_mismatch($sformatf("scl_level %b, want %b", got.scl_level, want.scl_level));
    if (got.sda_level !== want.sda_level)
      report_mismatch($sformatf("sda_level %b, want %b", got.sda_level, want.sda_level));
    if (got.busy_res !== want.busy_res)
      report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
    if (got.done_res !== want.done_res)
      report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
    if (got.read_data !== want.read_data)
      report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
    if (got.ack_failed !== want.ack_failed)
      report_mismatch($sformatf("ack_failed %b, want %b", got.ack_failed, want.ack_failed));
  endtask

  // Wait per beat: mostly a uniform random draw, with runs of back-to-back beats
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------
  task automatic send_beat(logic [2:0] op, logic [7:0] data, logic ack, logic sdai,
                           bit typed, result_t want);
    int      gap;
    result_t exp_r;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    data_byte = data;
    send_ack  = ack;
    sda_in    = sdai;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    exp_r = predict_beat(op, data, ack, sdai);
    if (typed) exp_r = want;
    result_q.push_back(exp_r);
    @(negedge clk);
  endtask

  // Stop offering and let every expected result come back
  task automatic drain();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_HALF_PERIOD) half_ticks = val;
    else poll_limit = val;
  endtask

  // One random phase: config, then command sequences until the budget is used
  // and the bus is idle again
  task automatic run_phase(logic [7:0] hp, logic [7:0] polls, int budget,
                           int op_lo, int op_hi, int low_pct, int hold, bit pause_mid);
    int         left;
    bit         paused;
    logic [2:0] op;
    logic       sdai;
    int         pick;
    drain();
    write_reg(CFG_HALF_PERIOD, hp);
    write_reg(CFG_ACK_TIMEOUT, polls);
    hold_req = hold;
    left = budget;
    paused = 1'b0;
    while (left > 0 || bus_ph != PH_IDLE) begin
      if (bus_ph == PH_IDLE) begin
        if ($urandom_range(0, 9) != 0) begin
          op = 3'($urandom_range(op_lo, op_hi));
        end else begin
          // noise while idle: tick or reserved code
          pick = $urandom_range(0, 2);
          op = (pick == 0) ? OP_TICK : ((pick == 1) ? OP_RSVD6 : OP_RSVD7);
        end
      end else if (left > 0 && $urandom_range(0, 15) == 0) begin
        op = 3'($urandom_range(1, 7));  // command while busy, dropped
      end else begin
        op = OP_TICK;
      end
      if (bus_ph == PH_WA_POLL) sdai = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
      else sdai = 1'($urandom_range(0, 1));
      send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sdai,
                1'b0, '0);
      if (beat_counted && left > 0) left--;
      if (pause_mid && !paused && left <= budget / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       ack;
    logic       sdai;
    logic [9:0] reps;
    logic       typed;
    result_t    want;
  } stim_row_t;

  stim_row_t dir_tab[$];

  function automatic stim_row_t row(logic [2:0] op, logic [7:0] data, logic ack,
                                    logic sdai, int reps, bit typed, result_t want);
    stim_row_t r;
    r.op    = op;
    r.data  = data;
    r.ack   = ack;
    r.sdai  = sdai;
    r.reps  = 10'(reps);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Main stimulus
  initial begin
    engine_reset();
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed table, one tick per phase, ack timeout of two polls
    write_reg(CFG_HALF_PERIOD, 8'd1);
    write_reg(CFG_ACK_TIMEOUT, 8'd2);
    // idle after reset, reserved codes ignored
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b0, 1, 1, mk_res(1, 1, 0, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_RSVD6, 8'hFF, 1'b1, 1'b1, 1, 1, mk_res(1, 1, 0, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_RSVD7, 8'h00, 1'b0, 1'b0, 1, 1, mk_res(1, 1, 0, 0, 8'h00, 0)));
    // start, with a command dropped while busy
    dir_tab.push_back(row(OP_START, 8'h00, 1'b0, 1'b0, 1, 1, mk_res(1, 1, 1, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1, 1, mk_res(1, 1, 1, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 1, 1, mk_res(1, 0, 1, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 1, 1, mk_res(0, 0, 0, 1, 8'h00, 0)));
    // byte writes, all ones then all zeros
    dir_tab.push_back(row(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b0, 24, 0, '0));
    dir_tab.push_back(row(OP_WRITE, 8'h00, 1'b1, 1'b1, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'hFF, 1'b1, 1'b1, 24, 0, '0));
    // reads: all ones with ACK, all zeros with NACK
    dir_tab.push_back(row(OP_READ,  8'h00, 1'b1, 1'b0, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 18, 0, '0));
    dir_tab.push_back(row(OP_READ,  8'hFF, 1'b0, 1'b1, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'hFF, 1'b1, 1'b0, 18, 0, '0));
    // wait-for-ack answered on the first poll
    dir_tab.push_back(row(OP_WACK,  8'h00, 1'b0, 1'b0, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 2, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b0, 1, 0, '0));
    // wait-for-ack timing out into a stop, flag holds until the next command
    dir_tab.push_back(row(OP_WACK,  8'h5A, 1'b1, 1'b1, 1, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 4, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 2, 0, '0));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b1, 1, 1, mk_res(1, 1, 0, 1, 8'h00, 1)));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b0, 1, 1, mk_res(1, 1, 0, 0, 8'h00, 1)));
    dir_tab.push_back(row(OP_STOP,  8'h00, 1'b0, 1'b0, 1, 1, mk_res(0, 0, 1, 0, 8'h00, 0)));
    dir_tab.push_back(row(OP_TICK,  8'h00, 1'b0, 1'b0, 3, 0, '0));
    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps)
        send_beat(dir_tab[i].op, dir_tab[i].data, dir_tab[i].ack, dir_tab[i].sdai,
                  dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases: hp, polls, budget, ops, poll-low odds, rx hold, mid pause
    run_phase(8'd1,   8'd1,   60,  1, 5, 30, 0,   1'b0);
    run_phase(8'd2,   8'd3,   100, 1, 5, 20, 300, 1'b0);
    run_phase(8'd0,   8'd0,   60,  1, 5, 20, 0,   1'b0);
    run_phase(8'd1,   8'd255, 60,  5, 5, 0,  0,   1'b0);
    run_phase(8'd12,  8'd4,   10,  1, 2, 50, 0,   1'b0);
    run_phase(8'd3,   8'd7,   150, 1, 5, 15, 0,   1'b1);
    run_phase(8'd1,   8'd2,   60,  1, 5, 25, 0,   1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = draw_wait(rx_burst);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      check_result(mk_res(scl_level, sda_level, busy_res, done_res, read_data, ack_failed));
      @(negedge clk);
    end
  end

endmodule

// File: sim.f
design/i2cm_pkg.sv
design/i2cm_phase_fsm.sv
design/i2c_master_bit_engine_core.sv
dv/tb_i2c_master_bit_engine_core.sv
